FILE: hdl/pqse_pkg.sv
// Shared types and constants of the product-quantisation subspace encoder.
package pqse_pkg;

    // Fixed field widths of the interface.
    localparam int C_CFG_W   = 9;   // widest configuration register
    localparam int C_IDX_W   = 2;   // configuration register index
    localparam int C_VAL_W   = 16;  // element or codebook word as delivered
    localparam int C_DIMV_W  = 8;   // dimension values and element positions
    localparam int C_SUB_W   = 5;   // subspace counts and boundary remainders
    localparam int C_CENT_W  = 8;   // centroid numbers carried between modules
    localparam int C_EXT_W   = 17;  // element after extension, always signed
    localparam int C_DIFF_W  = 18;  // difference of two extended elements
    localparam int C_SQ_W    = 35;  // square of a difference, never negative
    localparam int C_DIST_W  = 48;  // accumulated squared distance

    // Restoring division of the dimension by the subspace count.
    localparam int C_DIV_STEPS = C_DIMV_W;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_STEPS);

    // Configuration register indexes.
    localparam logic [C_IDX_W-1:0] C_REG_DIMENSION      = 2'd0;
    localparam logic [C_IDX_W-1:0] C_REG_SUBSPACE_COUNT = 2'd1;
    localparam logic [C_IDX_W-1:0] C_REG_CENTROID_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [C_DIMV_W-1:0] C_RST_DIMENSION      = 8'd128;
    localparam logic [C_SUB_W-1:0]  C_RST_SUBSPACE_COUNT = 5'd8;
    localparam logic [C_CFG_W-1:0]  C_RST_CENTROID_COUNT = 9'd256;

    // Input transaction modes.
    localparam logic C_MODE_LOAD    = 1'b0;
    localparam logic C_MODE_ELEMENT = 1'b1;

    // One step of the distance scan handed to the distance unit.
    typedef struct packed {
        logic                valid;
        logic                first;     // first dimension of the slice
        logic                last;      // last dimension of the slice
        logic [C_CENT_W-1:0] centroid;
        logic [C_DIMV_W-1:0] dim;
    } t_issue;

    // A finished distance from one centroid to the current slice.
    typedef struct packed {
        logic                valid;
        logic [C_CENT_W-1:0] centroid;
        logic [C_DIST_W-1:0] distance;
    } t_dist;

endpackage

FILE: hdl/pqse_dist_unit.sv
// Codebook and vector stores with the shared pipelined multiply-accumulate.
module pqse_dist_unit #(
    parameter int MAX_DIM       = 128,
    parameter int MAX_CENTROIDS = 256,
    parameter int ELEMENT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cb_we,
    input  logic [pqse_pkg::C_CENT_W-1:0]       i_cb_centroid,
    input  logic [6:0]                          i_cb_dim,
    input  logic                                i_vb_we,
    input  logic [pqse_pkg::C_DIMV_W-1:0]       i_vb_pos,
    input  logic [pqse_pkg::C_VAL_W-1:0]        i_wdata,
    input  pqse_pkg::t_issue                    i_issue,
    output pqse_pkg::t_dist                     o_dist,
    output logic                                o_busy
);

    localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [pqse_pkg::C_VAL_W-1:0] r_codebook [MAX_CENTROIDS][MAX_DIM];
    logic [pqse_pkg::C_VAL_W-1:0] r_vector   [MAX_DIM];

    logic                          w_cb_ok;
    logic [pqse_pkg::C_VAL_W-1:0]  r_cb_q;
    logic [pqse_pkg::C_VAL_W-1:0]  r_vb_q;
    pqse_pkg::t_issue              r_rd;
    pqse_pkg::t_issue              r_sq_tag;
    logic [pqse_pkg::C_SQ_W-1:0]   r_sq;
    logic [pqse_pkg::C_DIST_W-1:0] r_acc;
    pqse_pkg::t_dist               r_dist;

    logic signed [pqse_pkg::C_EXT_W-1:0]    w_cb_ext;
    logic signed [pqse_pkg::C_EXT_W-1:0]    w_vb_ext;
    logic signed [pqse_pkg::C_DIFF_W-1:0]   w_diff;
    logic signed [2*pqse_pkg::C_DIFF_W-1:0] w_prod;
    logic [pqse_pkg::C_DIST_W-1:0]          w_sum;

    function automatic logic signed [pqse_pkg::C_DIFF_W-1:0] C_DIFF_EXT(
        input logic signed [pqse_pkg::C_EXT_W-1:0] v
    );
        C_DIFF_EXT = {v[pqse_pkg::C_EXT_W-1], v};
    endfunction

    assign w_cb_ok = i_cb_we && (int'(i_cb_centroid) < MAX_CENTROIDS)
                             && (int'(i_cb_dim) < MAX_DIM);

    // Stores: one write port each, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_cb_ok) begin
            r_codebook[CW'(i_cb_centroid)][DW'(i_cb_dim)] <= i_wdata;
        end
        if (i_vb_we) begin
            r_vector[DW'(i_vb_pos)] <= i_wdata;
        end
        r_cb_q <= r_codebook[CW'(i_issue.centroid)][DW'(i_issue.dim)];
        r_vb_q <= r_vector[DW'(i_issue.dim)];
    end

    // Only the low ELEMENT_BITS bits carry the value; wider settings see the
    // delivered word as unsigned.
    generate
        if (ELEMENT_BITS > pqse_pkg::C_VAL_W) begin : g_zext
            assign w_cb_ext = $signed({1'b0, r_cb_q});
            assign w_vb_ext = $signed({1'b0, r_vb_q});
        end else begin : g_sext
            localparam int PAD = pqse_pkg::C_EXT_W - ELEMENT_BITS;
            logic signed [pqse_pkg::C_EXT_W-1:0] w_cb_top;
            logic signed [pqse_pkg::C_EXT_W-1:0] w_vb_top;
            assign w_cb_top = $signed({r_cb_q[ELEMENT_BITS-1:0], {PAD{1'b0}}});
            assign w_vb_top = $signed({r_vb_q[ELEMENT_BITS-1:0], {PAD{1'b0}}});
            assign w_cb_ext = w_cb_top >>> PAD;
            assign w_vb_ext = w_vb_top >>> PAD;
        end
    endgenerate

    assign w_diff = C_DIFF_EXT(w_vb_ext) - C_DIFF_EXT(w_cb_ext);
    assign w_prod = w_diff * w_diff;
    assign w_sum  = (r_sq_tag.first ? '0 : r_acc)
                  + pqse_pkg::C_DIST_W'(r_sq);

    // Pipeline payload, with only the valid bits reset.
    always_ff @(posedge i_clk) begin
        r_rd.first       <= i_issue.first;
        r_rd.last        <= i_issue.last;
        r_rd.centroid    <= i_issue.centroid;
        r_rd.dim         <= i_issue.dim;
        r_sq_tag.first    <= r_rd.first;
        r_sq_tag.last     <= r_rd.last;
        r_sq_tag.centroid <= r_rd.centroid;
        r_sq_tag.dim      <= r_rd.dim;
        // The square is never negative and stays below two to the 34.
        r_sq             <= w_prod[pqse_pkg::C_SQ_W-1:0];
        if (r_sq_tag.valid) begin
            r_acc <= w_sum;
        end
        r_dist.centroid  <= r_sq_tag.centroid;
        r_dist.distance  <= w_sum;
        if (!i_rst_n) begin
            r_rd.valid     <= 1'b0;
            r_sq_tag.valid <= 1'b0;
            r_dist.valid   <= 1'b0;
        end else begin
            r_rd.valid     <= i_issue.valid;
            r_sq_tag.valid <= r_rd.valid;
            r_dist.valid   <= r_sq_tag.valid && r_sq_tag.last;
        end
    end

    assign o_dist = r_dist;
    assign o_busy = r_rd.valid || r_sq_tag.valid || r_dist.valid;

endmodule

FILE: hdl/pq_subspace_encoder.sv
// Product-quantisation encoder: sequencer, boundary tracking and nearest-centroid search.
// An element that ends no subspace, and a codebook load, leave the input ready.
// An element that ends a subspace starts a scan over the active centroids, and no
// transaction is accepted until its code is registered once any earlier code is taken.
// After reset and after every write to one of the three configuration registers a
// restoring divider derives the subspace bounds, during which no transaction is accepted.
// Reset is synchronous and active low; the codebook and vector stores are not cleared.
module pq_subspace_encoder #(
    parameter int MAX_DIM       = 128,
    parameter int MAX_CENTROIDS = 256,
    parameter int MAX_SUBSPACES = 16,
    parameter int ELEMENT_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pqse_pkg::C_IDX_W-1:0]   i_cfg_index,
    input  logic [pqse_pkg::C_CFG_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [7:0]                     i_centroid_index,
    input  logic [6:0]                     i_dim_index,
    input  logic signed [15:0]             i_element_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [3:0]                     o_subspace_index,
    output logic [7:0]                     o_code,
    output logic                           o_last
);

    localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DV = pqse_pkg::C_DIMV_W;
    localparam int SB = pqse_pkg::C_SUB_W;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_DIV   = 5'b00010,
        S_IDLE  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [DV-1:0]                r_dimension;
    logic [SB-1:0]                r_subspace_count;
    logic [pqse_pkg::C_CFG_W-1:0] r_centroid_count;

    // Effective configuration.
    logic [DV-1:0] w_dim;
    logic [SB-1:0] w_sub;
    logic [CW-1:0] w_cent_last;

    // Divider.
    logic [pqse_pkg::C_DIV_CNT_W-1:0] r_div_cnt;
    logic [DV-1:0]                    r_div_q;
    logic [SB-1:0]                    r_div_rem;
    logic [SB:0]                      w_div_try;
    logic                             w_div_ge;
    logic [DV-1:0]                    r_quot;
    logic [SB-1:0]                    r_rmd;

    // Subspace tracking.
    logic [DV-1:0] r_pos;
    logic [SB-1:0] r_cur_sub;
    logic [DV-1:0] r_next_bnd;
    logic [DV-1:0] r_begin;
    logic [SB-1:0] r_bnd_rem;
    logic [SB:0]   w_rem_sum;
    logic [SB-1:0] w_rem_new;
    logic [SB:0]   w_rem_look;
    logic          w_sub_last;

    // Scan.
    logic [DV-1:0] r_scan_begin;
    logic [DV-1:0] r_scan_end;
    logic [CW-1:0] r_c;
    logic [DV-1:0] r_d;
    logic [SB-1:0] r_res_sub;
    logic          r_res_last;
    logic          r_issuing;

    logic [pqse_pkg::C_DIST_W-1:0] r_best_dist;
    logic [CW-1:0]                 r_best_c;

    logic                       w_in_acc;
    logic                       w_elem;
    logic                       w_bnd_hit;
    logic                       w_cfg_hit;
    logic                       w_out_free;
    pqse_pkg::t_issue           w_issue;
    pqse_pkg::t_dist            w_dist;
    logic                       w_busy;

    logic                 r_o_valid;
    logic [3:0]           r_o_sub;
    logic [7:0]           r_o_code;
    logic                 r_o_last;

    // Clamp the registers to their legal ranges.
    always_comb begin
        logic [SB-1:0] s;
        if (r_dimension == '0) begin
            w_dim = DV'(1);
        end else if (int'(r_dimension) > MAX_DIM) begin
            w_dim = DV'(MAX_DIM);
        end else begin
            w_dim = r_dimension;
        end
        if (r_subspace_count == '0) begin
            s = SB'(1);
        end else if (int'(r_subspace_count) > MAX_SUBSPACES) begin
            s = SB'(MAX_SUBSPACES);
        end else begin
            s = r_subspace_count;
        end
        if (DV'(s) > w_dim) begin
            w_sub = SB'(w_dim);
        end else begin
            w_sub = s;
        end
        if (r_centroid_count < pqse_pkg::C_CFG_W'(2)) begin
            w_cent_last = CW'(1);
        end else if (int'(r_centroid_count) > MAX_CENTROIDS) begin
            w_cent_last = CW'(MAX_CENTROIDS - 1);
        end else begin
            w_cent_last = CW'(r_centroid_count - pqse_pkg::C_CFG_W'(1));
        end
    end

    assign w_div_try = {r_div_rem, r_div_q[DV-1]};
    assign w_div_ge  = (w_div_try >= {1'b0, w_sub});

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_elem     = w_in_acc && (i_mode == pqse_pkg::C_MODE_ELEMENT);
    assign w_bnd_hit  = (r_pos + DV'(1)) == r_next_bnd;
    assign w_sub_last = ({1'b0, r_cur_sub} + (SB+1)'(1)) >= {1'b0, w_sub};
    assign w_cfg_hit  = i_cfg_we && ((i_cfg_index == pqse_pkg::C_REG_DIMENSION)
                                  || (i_cfg_index == pqse_pkg::C_REG_SUBSPACE_COUNT)
                                  || (i_cfg_index == pqse_pkg::C_REG_CENTROID_COUNT));
    assign w_out_free = !r_o_valid || i_out_ready;

    // The running remainder gives the next bound without a divider.
    assign w_rem_sum  = {1'b0, r_bnd_rem} + {1'b0, r_rmd};
    assign w_rem_new  = (w_rem_sum >= {1'b0, w_sub}) ? SB'(w_rem_sum - {1'b0, w_sub})
                                                     : SB'(w_rem_sum);
    assign w_rem_look = {1'b0, w_rem_new} + {1'b0, r_rmd};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == pqse_pkg::C_DIV_CNT_W'(pqse_pkg::C_DIV_STEPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_elem && w_bnd_hit) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_issuing && !w_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_LOAD;
        endcase
        if (w_cfg_hit) begin
            n_state = S_LOAD;
        end
    end

    always_comb begin
        w_issue.valid    = r_issuing;
        w_issue.first    = (r_d == r_scan_begin);
        w_issue.last     = (r_d == r_scan_end);
        w_issue.centroid = pqse_pkg::C_CENT_W'(r_c);
        w_issue.dim      = r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_LOAD;
            r_dimension      <= pqse_pkg::C_RST_DIMENSION;
            r_subspace_count <= pqse_pkg::C_RST_SUBSPACE_COUNT;
            r_centroid_count <= pqse_pkg::C_RST_CENTROID_COUNT;
            r_div_cnt        <= '0;
            r_pos            <= '0;
            r_cur_sub        <= '0;
            r_next_bnd       <= '0;
            r_begin          <= '0;
            r_bnd_rem        <= '0;
            r_issuing        <= 1'b0;
            r_o_valid        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    pqse_pkg::C_REG_DIMENSION:      r_dimension <= i_cfg_data[DV-1:0];
                    pqse_pkg::C_REG_SUBSPACE_COUNT: r_subspace_count <= i_cfg_data[SB-1:0];
                    pqse_pkg::C_REG_CENTROID_COUNT: r_centroid_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_LOAD) begin
                r_div_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + pqse_pkg::C_DIV_CNT_W'(1);
                if (r_div_cnt == pqse_pkg::C_DIV_CNT_W'(pqse_pkg::C_DIV_STEPS - 1)) begin
                    // Final quotient bit arrives now; start the vector afresh.
                    r_pos      <= '0;
                    r_cur_sub  <= '0;
                    r_bnd_rem  <= '0;
                    r_begin    <= '0;
                    r_next_bnd <= {r_div_q[DV-2:0], w_div_ge};
                end
            end

            if (w_elem) begin
                if (!w_bnd_hit) begin
                    r_pos <= r_pos + DV'(1);
                end else if (w_sub_last) begin
                    r_pos      <= '0;
                    r_cur_sub  <= '0;
                    r_bnd_rem  <= '0;
                    r_begin    <= '0;
                    r_next_bnd <= r_quot;
                end else begin
                    r_pos      <= r_pos + DV'(1);
                    r_cur_sub  <= r_cur_sub + SB'(1);
                    r_bnd_rem  <= w_rem_new;
                    r_begin    <= r_next_bnd;
                    r_next_bnd <= r_next_bnd + r_quot
                                + ((w_rem_look >= {1'b0, w_sub}) ? DV'(1) : DV'(0));
                end
                if (w_bnd_hit) begin
                    r_issuing <= 1'b1;
                end
            end else if (r_issuing && w_issue.last && (r_c == w_cent_last)) begin
                r_issuing <= 1'b0;
            end

            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Divider datapath, scan counters and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_div_q   <= w_dim;
            r_div_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_div_q   <= {r_div_q[DV-2:0], w_div_ge};
            r_div_rem <= w_div_ge ? SB'(w_div_try - {1'b0, w_sub}) : SB'(w_div_try);
            if (r_div_cnt == pqse_pkg::C_DIV_CNT_W'(pqse_pkg::C_DIV_STEPS - 1)) begin
                r_quot <= {r_div_q[DV-2:0], w_div_ge};
                r_rmd  <= w_div_ge ? SB'(w_div_try - {1'b0, w_sub}) : SB'(w_div_try);
            end
        end

        if (w_elem && w_bnd_hit) begin
            r_scan_begin <= r_begin;
            r_scan_end   <= r_pos;
            r_res_sub    <= r_cur_sub;
            r_res_last   <= w_sub_last;
            r_c          <= '0;
            r_d          <= r_begin;
        end else if (r_issuing) begin
            if (w_issue.last) begin
                r_d <= r_scan_begin;
                r_c <= r_c + CW'(1);
            end else begin
                r_d <= r_d + DV'(1);
            end
        end

        // Strict compare keeps the lowest index on a tie.
        if (w_dist.valid) begin
            if (w_dist.centroid == '0 || w_dist.distance < r_best_dist) begin
                r_best_dist <= w_dist.distance;
                r_best_c    <= CW'(w_dist.centroid);
            end
        end

        if (r_state == S_DONE && w_out_free) begin
            r_o_sub  <= r_res_sub[3:0];
            r_o_code <= 8'(r_best_c);
            r_o_last <= r_res_last;
        end
    end

    pqse_dist_unit #(
        .MAX_DIM       (MAX_DIM),
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .ELEMENT_BITS  (ELEMENT_BITS)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cb_we       (w_in_acc && (i_mode == pqse_pkg::C_MODE_LOAD)),
        .i_cb_centroid (i_centroid_index),
        .i_cb_dim      (i_dim_index),
        .i_vb_we       (w_elem),
        .i_vb_pos      (r_pos),
        .i_wdata       (i_element_value),
        .i_issue       (w_issue),
        .o_dist        (w_dist),
        .o_busy        (w_busy)
    );

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_subspace_index = r_o_sub;
    assign o_code           = r_o_code;
    assign o_last           = r_o_last;

endmodule

FILE: tb/sv/pq_subspace_encoder_tb.sv
// Self-checking testbench for the product-quantisation subspace encoder.
module pq_subspace_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_DIM       = 128;
    localparam int     MAX_CENTROIDS = 256;
    localparam int     MAX_SUBSPACES = 16;
    localparam longint DIST_MAX      = (64'd1 << 48) - 1;
    localparam longint DIFF_LIMIT    = 64'd1 << 24;
    localparam int     CYCLE_LIMIT   = 4_000_000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     RANDOM_PHASES = 4;

    typedef struct packed {
        logic               mode;
        logic [7:0]         centroid;
        logic [6:0]         dim;
        logic signed [15:0] value;
    } pq_item_t;

    typedef struct packed {
        logic [3:0] subspace;
        logic [7:0] code;
        logic       is_last;
    } pq_code_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [pqse_pkg::C_IDX_W-1:0]  i_cfg_index = '0;
    logic [pqse_pkg::C_CFG_W-1:0]  i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          i_mode = 1'b0;
    logic [7:0]                    i_centroid_index = '0;
    logic [6:0]                    i_dim_index = '0;
    logic signed [15:0]            i_element_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [3:0]                    o_subspace_index;
    logic [7:0]                    o_code;
    logic                          o_last;

    pq_subspace_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_centroid_index (i_centroid_index),
        .i_dim_index      (i_dim_index),
        .i_element_value  (i_element_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_subspace_index (o_subspace_index),
        .o_code           (o_code),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    pq_item_t pending_items[$];
    pq_code_t expected_codes[$];

    int errors = 0;
    int items_in = 0;
    int codes_out = 0;
    int settings_run = 0;
    int cycle_count = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 52;
    logic hold_req = 1'b0;
    int hold_left = 0;

    // Predictor state: configuration, stores and subspace tracking.
    logic [7:0]         cfg_dim;
    logic [4:0]         cfg_sub;
    logic [8:0]         cfg_cent;
    logic signed [15:0] cb_model [MAX_CENTROIDS][MAX_DIM];
    logic signed [15:0] vec_model [MAX_DIM];
    int                 elem_pos;
    int                 cur_sub;
    int                 next_bnd;
    int                 bnd_rem;

    // Stimulus-side copy of the codebook, used to aim elements at centroids.
    logic signed [15:0] shadow_cb [MAX_CENTROIDS][MAX_DIM];
    bit                 loaded [MAX_CENTROIDS][MAX_DIM];
    int                 enq_pos = 0;
    int                 enq_target = 0;

    function automatic int eff_dim();
        int d;
        d = cfg_dim;
        if (d < 1) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        return d;
    endfunction

    function automatic int eff_sub();
        int s;
        s = cfg_sub;
        if (s < 1) s = 1;
        if (s > MAX_SUBSPACES) s = MAX_SUBSPACES;
        if (s > eff_dim()) s = eff_dim();
        return s;
    endfunction

    function automatic int eff_cent();
        int c;
        c = cfg_cent;
        if (c < 2) c = 2;
        if (c > MAX_CENTROIDS) c = MAX_CENTROIDS;
        return c;
    endfunction

    function automatic void restart_vector();
        elem_pos = 0;
        cur_sub  = 0;
        bnd_rem  = 0;
        next_bnd = eff_dim() / eff_sub();
    endfunction

    function automatic longint slice_dist(input int c, input int lo, input int hi);
        longint acc, diff, mag;
        acc = 0;
        for (int d = lo; d < hi && d < MAX_DIM; d++) begin
            diff = longint'(vec_model[d]) - longint'(cb_model[c][d]);
            mag = (diff < 0) ? -diff : diff;
            if (mag >= DIFF_LIMIT) acc += DIST_MAX;
            else acc += mag * mag;
            if (acc > DIST_MAX) acc = DIST_MAX;
        end
        return acc;
    endfunction

    // Applies one transaction to the predictor; returns 1 when it ends a subspace.
    function automatic bit encode_step(input pq_item_t it, output pq_code_t rec);
        int dim_e, sub_e, q, r, pos, lo, best_c;
        longint best_d, cand_d;
        dim_e = eff_dim();
        sub_e = eff_sub();
        q = dim_e / sub_e;
        r = dim_e % sub_e;
        rec = '0;
        if (it.mode == pqse_pkg::C_MODE_LOAD) begin
            cb_model[it.centroid][it.dim] = it.value;
            return 1'b0;
        end
        pos = elem_pos;
        if (pos >= MAX_DIM) pos = MAX_DIM - 1;
        vec_model[pos] = it.value;
        if (pos + 1 != next_bnd) begin
            elem_pos = pos + 1;
            return 1'b0;
        end
        lo = (cur_sub * dim_e) / sub_e;
        best_c = 0;
        best_d = slice_dist(0, lo, pos + 1);
        for (int c = 1; c < eff_cent(); c++) begin
            cand_d = slice_dist(c, lo, pos + 1);
            // Strictly smaller only, so a tie keeps the lower index.
            if (cand_d < best_d) begin
                best_d = cand_d;
                best_c = c;
            end
        end
        rec.subspace = cur_sub[3:0];
        rec.code     = best_c[7:0];
        rec.is_last  = (cur_sub + 1 >= sub_e);
        if (rec.is_last) begin
            restart_vector();
        end else begin
            cur_sub  = cur_sub + 1;
            elem_pos = pos + 1;
            bnd_rem  = bnd_rem + r;
            if (bnd_rem >= sub_e) bnd_rem = bnd_rem - sub_e;
            next_bnd = next_bnd + q;
            if (bnd_rem + r >= sub_e) next_bnd = next_bnd + 1;
        end
        return 1'b1;
    endfunction

    // Input driver: predicts on acceptance, then offers the next queued item.
    always @(posedge i_clk) begin : drive_proc
        pq_item_t acc_item;
        pq_item_t nxt;
        pq_code_t rec;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                acc_item = '{i_mode, i_centroid_index, i_dim_index, i_element_value};
                items_in++;
                if (encode_step(acc_item, rec)) expected_codes.push_back(rec);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_in_valid       <= 1'b1;
                    i_mode           <= nxt.mode;
                    i_centroid_index <= nxt.centroid;
                    i_dim_index      <= nxt.dim;
                    i_element_value  <= nxt.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The long receiver hold-off is counted here, apart from the random stalls.
    always @(posedge i_clk) begin
        if (hold_req) hold_left <= HOLD_CYCLES;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Output monitor: compares each code transaction with the oldest expectation.
    always @(posedge i_clk) begin : monitor_proc
        pq_code_t exp_code;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                codes_out++;
                if (expected_codes.size() == 0) begin
                    $error("unexpected code transaction: subspace %0d code %0d last %0b",
                           o_subspace_index, o_code, o_last);
                    errors++;
                end else begin
                    exp_code = expected_codes.pop_front();
                    if (o_subspace_index !== exp_code.subspace) begin
                        $error("subspace_index: expected %0d, actual %0d",
                               exp_code.subspace, o_subspace_index);
                        errors++;
                    end
                    if (o_code !== exp_code.code) begin
                        $error("code: expected %0d, actual %0d", exp_code.code, o_code);
                        errors++;
                    end
                    if (o_last !== exp_code.is_last) begin
                        $error("last: expected %0b, actual %0b", exp_code.is_last, o_last);
                        errors++;
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_load(input int c, input int d, input logic signed [15:0] v);
        pq_item_t it;
        it = '{pqse_pkg::C_MODE_LOAD, c[7:0], d[6:0], v};
        shadow_cb[c][d] = v;
        loaded[c][d] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Element transactions carry random values in the fields the block ignores.
    task automatic push_element(input logic signed [15:0] v);
        pq_item_t it;
        it = '{pqse_pkg::C_MODE_ELEMENT, 8'($urandom), 7'($urandom), v};
        enq_pos = (enq_pos + 1) % eff_dim();
        pending_items.push_back(it);
    endtask

    // Most elements sit on or near one centroid chosen per vector.
    function automatic logic signed [15:0] pick_element();
        int style;
        if (enq_pos == 0) enq_target = $urandom_range(eff_cent() - 1);
        style = $urandom_range(9);
        if (style < 3) return shadow_cb[enq_target][enq_pos];
        if (style < 7) return shadow_cb[enq_target][enq_pos] + 16'($urandom_range(14)) - 16'sd7;
        return 16'($urandom);
    endfunction

    task automatic fill_codebook();
        for (int c = 0; c < eff_cent(); c++)
            for (int d = 0; d < eff_dim(); d++)
                if (!loaded[c][d]) push_load(c, d, 16'($urandom));
    endtask

    // Waits until every item is taken and every code has arrived, then lets the
    // block finish any load or element still in hand.
    task automatic settle();
        while (pending_items.size() > 0 || i_in_valid || expected_codes.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [pqse_pkg::C_IDX_W-1:0] idx,
                             input logic [pqse_pkg::C_CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            pqse_pkg::C_REG_DIMENSION:      cfg_dim  = data[7:0];
            pqse_pkg::C_REG_SUBSPACE_COUNT: cfg_sub  = data[4:0];
            pqse_pkg::C_REG_CENTROID_COUNT: cfg_cent = data[8:0];
            default: ;
        endcase
        restart_vector();
        enq_pos = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input int dim_v, input int sub_v, input int cent_v,
                               input int n_items, input bit with_hold);
        settle();
        write_reg(pqse_pkg::C_REG_DIMENSION, dim_v[pqse_pkg::C_CFG_W-1:0]);
        write_reg(pqse_pkg::C_REG_SUBSPACE_COUNT, sub_v[pqse_pkg::C_CFG_W-1:0]);
        write_reg(pqse_pkg::C_REG_CENTROID_COUNT, cent_v[pqse_pkg::C_CFG_W-1:0]);
        settings_run++;
        fill_codebook();
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(9) < 2) begin
                // Stray loads, some outside the active centroids and dimensions.
                push_load($urandom_range(1) ? $urandom_range(255) : $urandom_range(eff_cent() - 1),
                          $urandom_range(1) ? $urandom_range(127) : $urandom_range(eff_dim() - 1),
                          16'($urandom));
            end else begin
                push_element(pick_element());
            end
        end
        if (with_hold) begin
            while (pending_items.size() > n_items / 2) @(negedge i_clk);
            @(posedge i_clk);
            hold_req <= 1'b1;
            @(posedge i_clk);
            hold_req <= 1'b0;
        end
    endtask

    initial begin
        int fix_dim  [6] = '{128, 1, 0, 255, 5, 7};
        int fix_sub  [6] = '{16, 1, 0, 31, 16, 3};
        int fix_cent [6] = '{2, 511, 0, 2, 7, 7};
        int fix_n    [6] = '{100, 100, 100, 100, 100, 100};
        int n_settings;
        int mode_sel;

        cfg_dim  = pqse_pkg::C_RST_DIMENSION;
        cfg_sub  = pqse_pkg::C_RST_SUBSPACE_COUNT;
        cfg_cent = pqse_pkg::C_RST_CENTROID_COUNT;
        restart_vector();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: four dimensions in two subspaces, two centroids.
        settle();
        write_reg(pqse_pkg::C_REG_DIMENSION, 9'd4);
        write_reg(pqse_pkg::C_REG_SUBSPACE_COUNT, 9'd2);
        write_reg(pqse_pkg::C_REG_CENTROID_COUNT, 9'd2);
        settings_run++;
        // The first two dimensions of both centroids match, so both tie there.
        push_load(0, 0, 16'sh7FFF);
        push_load(0, 1, 16'sh8000);
        push_load(0, 2, 16'sh0000);
        push_load(0, 3, 16'sh0000);
        push_load(1, 0, 16'sh7FFF);
        push_load(1, 1, 16'sh8000);
        push_load(1, 2, 16'sd100);
        push_load(1, 3, -16'sd100);
        push_load(255, 127, 16'shFFFF);
        push_element(16'sh7FFF);
        push_element(16'sh8000);
        push_element(16'sh0000);
        push_element(16'sh0000);
        // Largest possible differences, tied between the two centroids.
        push_element(16'sh8000);
        push_element(16'sh7FFF);
        push_element(16'sd100);
        push_element(-16'sd100);
        // A partial vector is dropped by the register write that follows.
        push_element(16'sd100);
        settle();
        write_reg(pqse_pkg::C_REG_SUBSPACE_COUNT, 9'd2);
        push_element(16'sd1);
        push_element(-16'sd1);
        push_element(16'sd99);
        push_element(-16'sd99);

        n_settings = 6 + RANDOM_PHASES;
        for (int ph = 0; ph < n_settings; ph++) begin
            mode_sel = (ph * 3) / n_settings;
            case (mode_sel)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph < 6)
                run_setting(fix_dim[ph], fix_sub[ph], fix_cent[ph], fix_n[ph], ph == 2);
            else
                run_setting($urandom_range(1, 24), $urandom_range(1, 16),
                            $urandom_range(2, 16), $urandom_range(70, 100), 1'b0);
        end
        settle();

        $display("tb: %0d input transactions and %0d codes over %0d register settings",
                 items_in, codes_out, settings_run);
        $display("tb: %0d mismatches found", errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
